/* rtl/core/cbpe_pkg.sv */
package cbpe_pkg;

	localparam int STATIONS  = 1000;
	localparam int STATION_W = 10;
	localparam int FRAC_BITS = 20;
	localparam int DIG_W     = FRAC_BITS / 2;
	localparam int PT_W      = 16;
	localparam int CFG_REGS  = 8;
	localparam int CFG_IDX_W = $clog2(CFG_REGS);

	// coefficients of the power basis: |a|, |c| < 2^18, |b| < 2^19
	localparam int COEF_W    = PT_W + 5;
	localparam int STEPS     = 3;
	localparam int CELLS     = 2 * STEPS;
	localparam int MUL_W     = 2 * FRAC_BITS + COEF_W + 3;
	localparam int ACC_W     = 3 * FRAC_BITS + PT_W + 4;
	localparam int TRUNC_SH  = 3 * FRAC_BITS;

	// s = round(t * 2^FRAC_BITS / STATIONS) by reciprocal multiplication
	localparam int N_W       = STATION_W + FRAC_BITS;
	localparam int RCP_SH    = N_W + $clog2(STATIONS);
	localparam int RCP_W     = N_W + 2;
	localparam int PROD_W    = N_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP =
		RCP_W'(((longint'(1) << RCP_SH) + longint'(STATIONS) - 1) / longint'(STATIONS));

	// clamp stage, multiply stage, cells, output register
	localparam int LATENCY   = 2 + CELLS + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P0_X,
		REG_P0_Y,
		REG_P1_X,
		REG_P1_Y,
		REG_P2_X,
		REG_P2_Y,
		REG_P3_X,
		REG_P3_Y
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a_x;
		logic signed [COEF_W-1:0] a_y;
		logic signed [COEF_W-1:0] b_x;
		logic signed [COEF_W-1:0] b_y;
		logic signed [COEF_W-1:0] c_x;
		logic signed [COEF_W-1:0] c_y;
		logic signed [COEF_W-1:0] p0_x;
		logic signed [COEF_W-1:0] p0_y;
	} coef_t;

	typedef struct packed {
		logic                    vld;
		logic [FRAC_BITS-1:0]    k;
		logic signed [MUL_W-1:0] mul_x;
		logic signed [MUL_W-1:0] mul_y;
		logic signed [ACC_W-1:0] acc_x;
		logic signed [ACC_W-1:0] acc_y;
	} lane_t;

endpackage

/* rtl/core/cbpe_cfg_regs.sv */
module cbpe_cfg_regs import cbpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [PT_W-1:0]      wr_data,
	output coef_t                coef
);

	logic [PT_W-1:0] reg_q [CFG_REGS];
	coef_t           coef_d;
	coef_t           coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++) reg_q[i] <= '0;
		end else if (wr_en) begin
			reg_q[wr_index] <= wr_data;
		end
	end

	always_comb begin
		logic signed [COEF_W-1:0] p0x, p1x, p2x, p3x;
		logic signed [COEF_W-1:0] p0y, p1y, p2y, p3y;
		logic signed [COEF_W-1:0] d1x, d2x, d1y, d2y;
		p0x = COEF_W'($signed(reg_q[REG_P0_X]));
		p1x = COEF_W'($signed(reg_q[REG_P1_X]));
		p2x = COEF_W'($signed(reg_q[REG_P2_X]));
		p3x = COEF_W'($signed(reg_q[REG_P3_X]));
		p0y = COEF_W'($signed(reg_q[REG_P0_Y]));
		p1y = COEF_W'($signed(reg_q[REG_P1_Y]));
		p2y = COEF_W'($signed(reg_q[REG_P2_Y]));
		p3y = COEF_W'($signed(reg_q[REG_P3_Y]));
		d1x = p1x - p0x;
		d2x = p2x - p1x;
		d1y = p1y - p0y;
		d2y = p2y - p1y;
		coef_d.p0_x = p0x;
		coef_d.p0_y = p0y;
		coef_d.c_x  = d1x + (d1x <<< 1);
		coef_d.c_y  = d1y + (d1y <<< 1);
		coef_d.b_x  = d2x + (d2x <<< 1) - coef_d.c_x;
		coef_d.b_y  = d2y + (d2y <<< 1) - coef_d.c_y;
		coef_d.a_x  = p3x - p0x - coef_d.c_x - coef_d.b_x;
		coef_d.a_y  = p3y - p0y - coef_d.c_y - coef_d.b_y;
	end

	always_ff @(posedge clk) begin
		coef_q <= coef_d;
	end

	assign coef = coef_q;

endmodule

/* rtl/core/cbpe_scale.sv */
module cbpe_scale import cbpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [STATION_W-1:0] station,
	output logic                 out_vld,
	output logic [FRAC_BITS-1:0] k
);

	localparam logic [STATION_W-1:0] T_MAX = STATION_W'(STATIONS - 1);

	logic                 vld_s1, vld_s2;
	logic [STATION_W-1:0] t_s1;
	logic [N_W-1:0]       num;
	logic [PROD_W-1:0]    prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// saturate to the last station
	always_ff @(posedge clk) begin
		t_s1 <= (station > T_MAX) ? T_MAX : station;
	end

	// t * 2^FRAC_BITS plus half a station, rounds the quotient to nearest
	assign num = {t_s1, {FRAC_BITS{1'b0}}} + N_W'(STATIONS / 2);

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(num) * PROD_W'(RCP);
	end

	assign out_vld = vld_s2;
	assign k       = prod_s2[RCP_SH +: FRAC_BITS];

endmodule

/* rtl/core/cbpe_cell.sv */
module cbpe_cell import cbpe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  hi_digit,
	input  lane_t din,
	output lane_t dout
);

	logic [DIG_W-1:0]            digit;
	logic signed [DIG_W:0]       digit_s;
	logic signed [MUL_W+DIG_W:0] prod_x, prod_y;
	lane_t                       nxt;
	lane_t                       pay_q;
	logic                        vld_q;

	assign digit   = hi_digit ? din.k[FRAC_BITS-1 -: DIG_W] : din.k[DIG_W-1:0];
	assign digit_s = $signed({1'b0, digit});
	assign prod_x  = (MUL_W + DIG_W + 1)'(din.mul_x) * (MUL_W + DIG_W + 1)'(digit_s);
	assign prod_y  = (MUL_W + DIG_W + 1)'(din.mul_y) * (MUL_W + DIG_W + 1)'(digit_s);

	// shift the running sum one digit up and add this digit's partial product
	always_comb begin
		nxt       = din;
		nxt.acc_x = (din.acc_x <<< DIG_W) + ACC_W'(prod_x);
		nxt.acc_y = (din.acc_y <<< DIG_W) + ACC_W'(prod_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	always_comb begin
		dout     = pay_q;
		dout.vld = vld_q;
	end

endmodule

/* rtl/core/cubic_bezier_point_eval.sv */
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------
// input    | start / busy              | station
// result   | done (one-cycle strobe)   | point_x, point_y
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One point per clock: busy stays low, a new station may enter every cycle.
// Each result passes through one clamp stage,
// one reciprocal multiply for s, six multiply-accumulate cells (three Horner
// steps, two 10-bit digits of s each) and the output register.
// arst_n clears the control points to zero and drops all items in flight.
// The receiver cannot stall; done is a strobe with no back-pressure.
module cubic_bezier_point_eval import cbpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [STATION_W-1:0] station,
	output logic                 done,
	output logic signed [PT_W-1:0] point_x,
	output logic signed [PT_W-1:0] point_y,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PT_W-1:0]      cfg_data
);

	coef_t                   coef;
	logic                    scale_vld;
	logic [FRAC_BITS-1:0]    scale_k;
	logic signed [ACC_W-1:0] seed_x [STEPS];
	logic signed [ACC_W-1:0] seed_y [STEPS];
	lane_t                   cell_in  [CELLS];
	lane_t                   cell_out [CELLS];
	logic signed [ACC_W-1:0] fin_x, fin_y;
	logic signed [ACC_W-1:0] rnd_x, rnd_y;
	logic                    done_q;
	logic signed [PT_W-1:0]  point_x_q, point_y_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	cbpe_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	cbpe_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start & ~busy),
		.station (station),
		.out_vld (scale_vld),
		.k       (scale_k)
	);

	// addends of the three Horner steps, pre-scaled so that two digit shifts land them
	always_comb begin
		seed_x[0] = ACC_W'(coef.b_x);
		seed_y[0] = ACC_W'(coef.b_y);
		seed_x[1] = ACC_W'(coef.c_x) <<< FRAC_BITS;
		seed_y[1] = ACC_W'(coef.c_y) <<< FRAC_BITS;
		seed_x[2] = ACC_W'(coef.p0_x) <<< (2 * FRAC_BITS);
		seed_y[2] = ACC_W'(coef.p0_y) <<< (2 * FRAC_BITS);
	end

	for (genvar j = 0; j < CELLS; j++) begin : g_cell
		if (j == 0) begin : g_first
			assign cell_in[j] = '{
				vld:   scale_vld,
				k:     scale_k,
				mul_x: MUL_W'(coef.a_x),
				mul_y: MUL_W'(coef.a_y),
				acc_x: seed_x[0],
				acc_y: seed_y[0]
			};
		end else if (j % 2 == 0) begin : g_step
			// the previous step's result becomes the multiplicand
			assign cell_in[j] = '{
				vld:   cell_out[j-1].vld,
				k:     cell_out[j-1].k,
				mul_x: $signed(cell_out[j-1].acc_x[MUL_W-1:0]),
				mul_y: $signed(cell_out[j-1].acc_y[MUL_W-1:0]),
				acc_x: seed_x[j/2],
				acc_y: seed_y[j/2]
			};
		end else begin : g_digit
			assign cell_in[j] = cell_out[j-1];
		end

		cbpe_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.hi_digit (j % 2 == 0),
			.din      (cell_in[j]),
			.dout     (cell_out[j])
		);
	end

	// truncate toward zero: bias negative sums by all ones below the point
	assign fin_x = cell_out[CELLS-1].acc_x;
	assign fin_y = cell_out[CELLS-1].acc_y;
	assign rnd_x = fin_x + $signed({{(ACC_W-TRUNC_SH){1'b0}}, {TRUNC_SH{fin_x[ACC_W-1]}}});
	assign rnd_y = fin_y + $signed({{(ACC_W-TRUNC_SH){1'b0}}, {TRUNC_SH{fin_y[ACC_W-1]}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cell_out[CELLS-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		point_x_q <= $signed(rnd_x[TRUNC_SH +: PT_W]);
		point_y_q <= $signed(rnd_y[TRUNC_SH +: PT_W]);
	end

	assign done    = done_q;
	assign point_x = point_x_q;
	assign point_y = point_y_q;

endmodule

/* rtl/core/cbpe_checker.sv */
module cbpe_checker import cbpe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_valid,
	input logic cfg_ready
);

	// every transfer yields its point
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted station produced no point");

	// no point without a matching earlier transfer
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && arst_n, LATENCY))
		else $error("point without a matching station");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && cfg_ready)
		else $error("input or config side stalled");

endmodule

bind cubic_bezier_point_eval cbpe_checker u_cbpe_checker (.*);
